@@ sv/cfsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_pkg
// shared types, codes and helpers of the can frame signal pack/unpack core
// ----------------------------------------------------------------------------
package cfsp_pkg;

  localparam int S_DATA_W  = 96;
  localparam int M_DATA_W  = 80;
  localparam int ROW_W     = 64;
  localparam int ROW_BYTES = 8;
  localparam int ROWS      = 8;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic       en;
    logic [2:0] addr;
    row_t       data;
  } wr_t;

  typedef enum logic [1:0] {
    MODE_INSERT     = 2'd0,
    MODE_EXTRACT    = 2'd1,
    MODE_WRITE_BYTE = 2'd2,
    MODE_READ_BYTE  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_SPAN  = 2'd3;

  function automatic logic [127:0] byte_rev(input logic [127:0] w);
    logic [127:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k*8 +: 8] = w[(15-k)*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] size_mask(input logic [6:0] size);
    logic [63:0] m;
    if (size >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'h0000000000000001 << size[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ sv/can_frame_signal_pack_unpack_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_signal_pack_unpack_core
// holds a can payload and inserts, extracts, writes or reads its contents
//
//   channel  dir  beat contents
//   s_*      in   tuser: mode; tdata: start_bit, bit_size, byte_order,
//                 signal_in, byte_index, byte_in
//   m_*      out  tuser: status; tdata: signal_out, used_length, byte_out
//   cfg_*    in   fd_frame, one bit
//
// each beat passes from acceptance to the result register through two row
// reads of the payload ram, one modify step, two row writes, one length step
// and the result load, then returns to idle.
// a new beat is taken once the previous one has left the sequencer, even
// while its result still waits on m_tready.
// reset clears the payload through per-byte nonzero flags at once.
// ----------------------------------------------------------------------------
module can_frame_signal_pack_unpack_core import cfsp_pkg::*; #(
  parameter int FD_PAYLOAD_BYTES = 64,
  parameter int MAX_SIGNAL_BITS  = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic                cfg_wdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // start_bit, bit_size, byte_order, signal_in, byte_index, byte_in
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // mode
  input  wire logic [1:0]          s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // signal_out, used_length, byte_out
  output logic [M_DATA_W-1:0]      m_tdata,
  // status
  output logic [1:0]               m_tuser
);

  localparam logic [6:0] FD_LEN   = 7'(FD_PAYLOAD_BYTES);
  localparam logic [6:0] MAX_BITS = 7'(MAX_SIGNAL_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_CALC, S_WR0, S_WR1, S_LEN, S_DONE
  } state_t;

  state_t      state;
  logic        fd;
  logic [6:0]  used_len;

  mode_t       in_mode;
  logic [8:0]  in_start;
  logic [6:0]  in_size;
  logic        in_order;
  logic [63:0] in_sig;
  logic [5:0]  in_bidx;
  logic [7:0]  in_bin;

  logic [6:0]  len;
  logic [9:0]  frame_bits;
  logic [6:0]  span_sum;
  logic [3:0]  span;
  logic [6:0]  intel_end;
  logic        size_bad;
  logic        span_bad;
  logic [1:0]  in_status;
  logic [2:0]  in_row_a;

  mode_t       op_mode;
  logic        op_order;
  logic [5:0]  op_shift;
  logic [6:0]  op_size;
  logic [63:0] op_sig;
  logic [2:0]  op_bsel;
  logic [7:0]  op_bin;
  logic [1:0]  op_status;
  logic [2:0]  row_a;
  logic [2:0]  row_b;
  row_t        ra;
  row_t        new_a;
  row_t        new_b;
  logic [63:0] res_sig;
  logic [7:0]  res_byte;

  row_t         rdata;
  row_t         rdata_m;
  logic [2:0]   raddr;
  wr_t          wr;
  logic [63:0]  nz;
  logic         found;
  logic [5:0]   hi_idx;
  logic [7:0]   nz_row;

  logic [127:0] win;
  logic [127:0] v;
  logic [63:0]  smask;
  logic [127:0] fmask;
  logic [127:0] ins;
  logic [127:0] new_win;
  logic [63:0]  field;
  logic         do_write;

  assign in_mode  = mode_t'(s_tuser);
  assign in_start = s_tdata[8:0];
  assign in_size  = s_tdata[15:9];
  assign in_order = s_tdata[16];
  assign in_sig   = s_tdata[80:17];
  assign in_bidx  = s_tdata[86:81];
  assign in_bin   = s_tdata[94:87];

  assign len        = fd ? FD_LEN : 7'd8;
  assign frame_bits = {len, 3'b000};
  assign span_sum   = 7'(in_start[2:0]) + in_size - 7'd1;
  assign span       = span_sum[6:3];
  assign intel_end  = 7'(in_start[8:3]) + 7'(span);

  always_comb begin
    size_bad = (in_size == 7'd0) || (in_size > MAX_BITS) || (10'(in_size) > frame_bits);
    span_bad = (7'(in_start[8:3]) >= len) ||
               (in_order ? (in_start[8:3] < 6'(span)) : (intel_end >= len));
    case (in_mode)
      MODE_INSERT, MODE_EXTRACT: begin
        if (size_bad) begin
          in_status = ST_SIZE;
        end else if (in_mode == MODE_INSERT && 10'(in_start) >= frame_bits) begin
          in_status = ST_START;
        end else if (span_bad) begin
          in_status = ST_SPAN;
        end else begin
          in_status = ST_OK;
        end
        in_row_a = in_order ? in_start[8:6] - 3'd1 : in_start[8:6];
      end
      default: begin
        in_status = (7'(in_bidx) >= len) ? ST_SPAN : ST_OK;
        in_row_a  = in_bidx[5:3];
      end
    endcase
  end

  // bytes never written since reset read as zero
  assign raddr  = (state == S_RD1) ? row_b : row_a;
  assign nz_row = nz[{(state == S_CALC) ? row_b : row_a, 3'b000} +: 8];

  always_comb begin
    for (int k = 0; k < ROW_BYTES; k++) begin
      rdata_m[k*8 +: 8] = rdata[k*8 +: 8] & {8{nz_row[k]}};
    end
  end

  always_comb begin
    win     = {rdata_m, ra};
    v       = op_order ? byte_rev(win) : win;
    smask   = size_mask(op_size);
    fmask   = {64'b0, smask} << op_shift;
    field   = 64'(v >> op_shift) & smask;
    ins     = (v & ~fmask) | ({64'b0, op_sig & smask} << op_shift);
    new_win = op_order ? byte_rev(ins) : ins;
    if (op_mode == MODE_WRITE_BYTE) begin
      new_win = win;
      new_win[{op_bsel, 3'b000} +: 8] = op_bin;
    end
  end

  assign do_write = (op_status == ST_OK) &&
                    (op_mode == MODE_INSERT || op_mode == MODE_WRITE_BYTE);

  always_comb begin
    wr.en   = do_write && (state == S_WR0 || state == S_WR1);
    wr.addr = (state == S_WR1) ? row_b : row_a;
    wr.data = (state == S_WR1) ? new_b : new_a;
  end

  cfsp_row_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  cfsp_nzmap u_nz (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .fd     (fd),
    .nz     (nz),
    .found  (found),
    .hi_idx (hi_idx)
  );

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fd       <= 1'b0;
      used_len <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        fd <= cfg_wdata;
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_mode   <= in_mode;
            op_order  <= in_order && (in_mode == MODE_INSERT || in_mode == MODE_EXTRACT);
            op_shift  <= in_order ? {~in_start[5:3], in_start[2:0]} : in_start[5:0];
            op_size   <= in_size;
            op_sig    <= in_sig;
            op_bsel   <= in_bidx[2:0];
            op_bin    <= in_bin;
            op_status <= in_status;
            row_a     <= in_row_a;
            row_b     <= in_row_a + 3'd1;
            state     <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          ra    <= rdata_m;
          state <= S_CALC;
        end
        S_CALC: begin
          new_a    <= new_win[63:0];
          new_b    <= new_win[127:64];
          res_sig  <= (op_mode == MODE_EXTRACT && op_status == ST_OK) ? field : '0;
          res_byte <= (op_mode == MODE_READ_BYTE && op_status == ST_OK) ?
                      ra[{op_bsel, 3'b000} +: 8] : '0;
          state    <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: state <= S_LEN;
        S_LEN: begin
          if (op_mode == MODE_INSERT && op_status == ST_OK && found) begin
            used_len <= 7'(hi_idx) + 7'd1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, res_byte, used_len, res_sig};
            m_tuser  <= op_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/cfsp_row_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_row_ram
// payload store, eight rows of eight bytes, registered read
// ----------------------------------------------------------------------------
module cfsp_row_ram import cfsp_pkg::*; (
  input  wire logic       clk,
  input  wire wr_t        wr,
  input  wire logic [2:0] raddr,
  output row_t            rdata
);

  row_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/cfsp_nzmap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_nzmap
// nonzero flag per payload byte, cleared at reset, with highest nonzero search
// ----------------------------------------------------------------------------
module cfsp_nzmap import cfsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire wr_t         wr,
  input  wire logic        fd,
  output logic [63:0]      nz,
  output logic             found,
  output logic [5:0]       hi_idx
);

  logic [ROWS-1:0] row_any;
  logic [2:0]      hr;
  logic [2:0]      hk;
  logic [7:0]      bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      nz <= '0;
    end else if (wr.en) begin
      for (int k = 0; k < ROW_BYTES; k++) begin
        nz[{wr.addr, 3'(k)}] <= |wr.data[k*8 +: 8];
      end
    end
  end

  always_comb begin
    found = 1'b0;
    hr    = '0;
    hk    = '0;
    for (int r = 0; r < ROWS; r++) begin
      row_any[r] = (|nz[r*8 +: 8]) && (fd || r == 0);
      if (row_any[r]) begin
        found = 1'b1;
        hr    = 3'(r);
      end
    end
    bits = nz[{hr, 3'b000} +: 8];
    for (int k = 0; k < ROW_BYTES; k++) begin
      if (bits[k]) begin
        hk = 3'(k);
      end
    end
    hi_idx = {hr, hk};
  end

endmodule
`default_nettype wire

@@ sv/cfsp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_props
// port-level checks of the pack/unpack core, bound to the top level
// ----------------------------------------------------------------------------
module cfsp_props import cfsp_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic [1:0]          m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a beat is in progress");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0 && m_tdata[78:71] == 8'd0)
    else $error("data on an error result");

  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[70:64] <= 7'd64)
    else $error("used length beyond frame");

endmodule

bind can_frame_signal_pack_unpack_core cfsp_props u_cfsp_props (.*);
`default_nettype wire

@@ verif/cfsp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfsp_checker
// watches the beat channels and config port of the signal pack/unpack core,
// keeps its own copy of the payload and used length, predicts each result
// and compares it field by field with what leaves the master side
// ----------------------------------------------------------------------------
module cfsp_checker import cfsp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic                cfg_wdata,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]          s_tuser,
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [M_DATA_W-1:0] m_tdata,
  input  wire logic [1:0]          m_tuser,
  output int                       errors,
  output int                       pending,
  output int                       beats_in,
  output int                       beats_out
);

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] signal_out;
    logic [6:0]  used_length;
    logic [7:0]  byte_out;
  } frame_result_t;

  logic [7:0]    payload [64];
  logic [6:0]    used_len;
  logic          fd_mode;
  frame_result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic int bit_byte(input logic [8:0] start, input int i,
                                  input logic order, input int len);
    int t;
    int b;
    t = int'(start[2:0]) + i;
    b = int'(start >> 3);
    b = order ? b - (t >> 3) : b + (t >> 3);
    if (b < 0 || b >= len) return -1;
    return b;
  endfunction

  task automatic predict_result(input logic [1:0] mode, input logic [S_DATA_W-1:0] d);
    logic [8:0]    start;
    logic [6:0]    size;
    logic          order;
    logic [63:0]   sig;
    logic [5:0]    bidx;
    logic [7:0]    bin;
    int            len;
    int            b;
    int            bitpos;
    bit            found;
    frame_result_t r;
    start = d[8:0];
    size  = d[15:9];
    order = d[16];
    sig   = d[80:17];
    bidx  = d[86:81];
    bin   = d[94:87];
    len   = fd_mode ? 64 : 8;
    r     = '0;
    r.status = ST_OK;
    if (mode == MODE_INSERT || mode == MODE_EXTRACT) begin
      if (size == 0 || size > 64 || int'(size) > len * 8) begin
        r.status = ST_SIZE;
      end else if (mode == MODE_INSERT && int'(start) >= len * 8) begin
        r.status = ST_START;
      end else if (bit_byte(start, 0, order, len) < 0 ||
                   bit_byte(start, int'(size) - 1, order, len) < 0) begin
        r.status = ST_SPAN;
      end else begin
        for (int i = 0; i < int'(size); i++) begin
          b = bit_byte(start, i, order, len);
          bitpos = (int'(start[2:0]) + i) & 7;
          if (b >= 0) begin
            if (mode == MODE_INSERT) payload[b][bitpos] = sig[i];
            else r.signal_out[i] = payload[b][bitpos];
          end
        end
        if (mode == MODE_INSERT) begin
          found = 0;
          for (int k = len - 1; k >= 0; k--) begin
            if (!found && payload[k] != 8'd0) begin
              used_len = 7'(k + 1);
              found = 1;
            end
          end
        end
      end
    end else if (int'(bidx) >= len) begin
      r.status = ST_SPAN;
    end else if (mode == MODE_WRITE_BYTE) begin
      payload[bidx] = bin;
    end else begin
      r.byte_out = payload[bidx];
    end
    r.used_length = used_len;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    frame_result_t e;
    frame_result_t a;
    if (rst) begin
      foreach (payload[k]) payload[k] = 8'd0;
      used_len  = '0;
      fd_mode   = 1'b0;
      errors    = 0;
      beats_in  = 0;
      beats_out = 0;
      expected_q.delete();
    end else begin
      if (cfg_wen) fd_mode = cfg_wdata;
      if (s_tvalid && s_tready) begin
        beats_in++;
        predict_result(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        beats_out++;
        a.status      = m_tuser;
        a.signal_out  = m_tdata[63:0];
        a.used_length = m_tdata[70:64];
        a.byte_out    = m_tdata[78:71];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", a);
        end else begin
          e = expected_q.pop_front();
          if (e != a) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: exp %p got %p", beats_out, e, a);
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_can_frame_signal_pack_unpack_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_frame_signal_pack_unpack_core
// drives directed and random insert, extract and raw byte beats through the
// core in classic and fd frame modes with random idling on both sides and
// leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module tb_can_frame_signal_pack_unpack_core;
  import cfsp_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic                cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  int errors;
  int pending;
  int beats_in;
  int beats_out;
  bit fd_cur;
  bit no_idle;
  bit hold_req;
  int stall_cycles;

  can_frame_signal_pack_unpack_core u_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  cfsp_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending), .beats_in(beats_in), .beats_out(beats_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // field order: start_bit, bit_size, byte_order, signal_in, byte_index, byte_in
  task automatic send_beat(input mode_t mode, input logic [8:0] start, input logic [6:0] size,
                           input logic order, input logic [63:0] sig,
                           input logic [5:0] bidx, input logic [7:0] bin);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = {1'b0, bin, bidx, sig, order, size, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_frame(input bit fd);
    drain();
    cfg_wen   = 1'b1;
    cfg_wdata = fd;
    fd_cur    = fd;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  function automatic bit span_ok(input logic [8:0] start, input int size,
                                 input logic order, input int len);
    int t;
    int b;
    t = int'(start[2:0]) + size - 1;
    b = int'(start >> 3);
    b = order ? b - (t >> 3) : b + (t >> 3);
    return b >= 0 && b < len && int'(start) < len * 8;
  endfunction

  task automatic random_beat();
    int          len;
    int          size;
    logic [8:0]  start;
    logic        order;
    logic [63:0] sig;
    mode_t       mode;
    logic [5:0]  bidx;
    logic [7:0]  bin;
    len   = fd_cur ? 64 : 8;
    mode  = mode_t'($urandom_range(0, 3));
    order = 1'($urandom_range(0, 1));
    sig   = {$urandom, $urandom};
    bidx  = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, len - 1));
    bin   = $urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom);
    start = 9'($urandom);
    size  = $urandom_range(1, len * 8 < 64 ? len * 8 : 64);
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 3) == 0) size = $urandom_range(1, 16);
      start = 9'($urandom_range(0, len * 8 - 1));
      while (!span_ok(start, size, order, len)) start = 9'($urandom_range(0, len * 8 - 1));
    end else if ($urandom_range(0, 2) == 0) begin
      size = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
    end
    send_beat(mode, start, 7'(size), order, sig, bidx, bin);
  endtask

  task automatic directed_set();
    int len;
    len = fd_cur ? 64 : 8;
    send_beat(MODE_INSERT, 9'd0, 7'd64, 1'b0, 64'hffff_ffff_ffff_ffff, 6'd0, 8'd0);
    send_beat(MODE_EXTRACT, 9'd0, 7'd64, 1'b0, '0, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd4, 7'd12, 1'b0, 64'h0, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd60, 7'd13, 1'b1, 64'h1abc, 6'd0, 8'd0);
    send_beat(MODE_EXTRACT, 9'd60, 7'd13, 1'b1, '0, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'(len * 8 - 1), 7'd1, 1'b0, 64'h1, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd0, 7'd0, 1'b0, 64'h1, 6'd0, 8'd0);
    send_beat(MODE_EXTRACT, 9'd0, 7'd65, 1'b0, '0, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd0, 7'd127, 1'b1, '1, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd511, 7'd1, 1'b0, '1, 6'd0, 8'd0);
    send_beat(MODE_EXTRACT, 9'd511, 7'd1, 1'b0, '0, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'd3, 7'd8, 1'b1, 64'hff, 6'd0, 8'd0);
    send_beat(MODE_INSERT, 9'(len * 8 - 4), 7'd8, 1'b0, 64'hff, 6'd0, 8'd0);
    send_beat(MODE_WRITE_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'(len - 1), 8'hff);
    send_beat(MODE_READ_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'(len - 1), 8'd0);
    send_beat(MODE_WRITE_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'd63, 8'h5a);
    send_beat(MODE_READ_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'd63, 8'd0);
    send_beat(MODE_READ_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'd8, 8'd0);
    for (int k = 0; k < len; k++)
      send_beat(MODE_WRITE_BYTE, 9'd0, 7'd0, 1'b0, '0, 6'(k), 8'd0);
    send_beat(MODE_INSERT, 9'd5, 7'd3, 1'b0, 64'h0, 6'd0, 8'd0);
    send_beat(MODE_EXTRACT, 9'd0, 7'd64, 1'b1, '0, 6'd0, 8'd0);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    m_tready     = 1'b0;
    stall_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (300) begin
          stall_cycles++;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle = 0;
      else idle++;
      if (idle >= 20000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_INSERT;
    fd_cur    = 1'b0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    set_frame(1'b0);
    directed_set();
    set_frame(1'b1);
    directed_set();
    hold_req = 1'b1;
    repeat (60) random_beat();
    for (int ph = 0; ph < 6; ph++) begin
      set_frame(ph % 3 != 0);
      if (ph == 5) no_idle = 1'b1;
      repeat (150) random_beat();
      if (ph == 2) drain();
    end
    drain();
    $display("covered %0d beats in, %0d results, classic and fd frames, %0d hold-off cycles",
             beats_in, beats_out, stall_cycles);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cfsp_pkg.sv
sv/cfsp_row_ram.sv
sv/cfsp_nzmap.sv
sv/can_frame_signal_pack_unpack_core.sv
sv/cfsp_checker.sv
verif/cfsp_checker.sv
verif/tb_can_frame_signal_pack_unpack_core.sv
